>>> hdl/chc_pkg.sv
// Shared types, constants and constant functions for the cubehelix color evaluator.
package chc_pkg;

  localparam int LEVEL_BITS_DEF = 16;
  localparam int ROTATION_STAGES_DEF = 16;
  localparam int ATAN_LEN = 24;

  // Register map indexes
  localparam logic [1:0] REG_START_HUE  = 2'd0;
  localparam logic [1:0] REG_ROTATIONS  = 2'd1;
  localparam logic [1:0] REG_SAT_GAIN   = 2'd2;
  localparam logic [1:0] REG_GAMMA      = 2'd3;

  localparam logic [9:0]  START_HUE_RST = 10'd128;
  localparam logic [11:0] ROTATIONS_RST = 12'hE80;
  localparam logic [10:0] SAT_GAIN_RST  = 11'd384;
  localparam logic [10:0] GAMMA_RST     = 11'd256;

  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
  localparam logic [31:0] ONE30 = 32'h4000_0000;

  // Channel weights, Q.16
  localparam logic signed [18:0] W_R_C = -19'sd9739;
  localparam logic signed [18:0] W_R_S = 19'sd116836;
  localparam logic signed [18:0] W_G_C = -19'sd19154;
  localparam logic signed [18:0] W_G_S = -19'sd59408;
  localparam logic signed [18:0] W_B_C = 19'sd129299;

  // Rotation angles in units of 2^-32 turn
  localparam logic [31:0] ATAN_TURNS [ATAN_LEN] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
    32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  typedef struct packed {
    logic              nz;
    logic [1:0]        q;
    logic signed [33:0] x;
    logic signed [33:0] y;
    logic signed [33:0] z;
    logic [4:0]        p;
    logic [31:0]       m;
    logic [23:0]       frac;
    logic signed [9:0] n;
    logic [23:0]       f;
    logic [31:0]       e;
  } item_t;

  function automatic logic [63:0] isqrt64(input logic [63:0] v);
    logic [63:0] res;
    logic [63:0] bit_v;
    logic [63:0] rem;
    res = 64'd0;
    bit_v = 64'h4000_0000_0000_0000;
    rem = v;
    for (int i = 0; i < 32; i++) begin
      if (rem >= res + bit_v) begin
        rem = rem - (res + bit_v);
        res = (res >> 1) + bit_v;
      end else begin
        res = res >> 1;
      end
      bit_v = bit_v >> 2;
    end
    return res;
  endfunction

  // 2^(2^-(24-k)) in Q1.30, built as a truncated square root chain
  function automatic logic [63:0] exp_root(input int k);
    logic [63:0] root;
    root = isqrt64(64'h2000_0000_0000_0000);
    for (int j = ATAN_LEN - 1; j > k; j--) begin
      root = isqrt64(root << 30);
    end
    return root;
  endfunction

endpackage

>>> hdl/chc_cordic_cell.sv
// One CORDIC rotation cell of the phase-to-cos/sin chain.
module chc_cordic_cell #(
  parameter int STAGE = 0
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_v,
  input  chc_pkg::item_t in_item,
  output logic          out_v,
  output chc_pkg::item_t out_item
);

  localparam logic signed [33:0] ANGLE = $signed({2'b00, chc_pkg::ATAN_TURNS[STAGE]});

  logic          v_r;
  chc_pkg::item_t item_r, item_nxt;
  logic signed [33:0] dx, dy;

  always_comb begin
    dx = in_item.y >>> STAGE;
    dy = in_item.x >>> STAGE;
    item_nxt = in_item;
    if (!in_item.z[33]) begin
      item_nxt.x = in_item.x - dx;
      item_nxt.y = in_item.y + dy;
      item_nxt.z = in_item.z - ANGLE;
    end else begin
      item_nxt.x = in_item.x + dx;
      item_nxt.y = in_item.y - dy;
      item_nxt.z = in_item.z + ANGLE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      item_r <= item_nxt;
    end
  end

  assign out_v = v_r;
  assign out_item = item_r;

endmodule

>>> hdl/chc_log_cell.sv
// One squaring cell of the log2 fraction chain; yields one fraction bit.
module chc_log_cell #(
  parameter int BIT_POS = 23
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_v,
  input  chc_pkg::item_t in_item,
  output logic          out_v,
  output chc_pkg::item_t out_item
);

  logic          v_r;
  chc_pkg::item_t item_r, item_nxt;
  logic [63:0]   sq;
  logic [31:0]   m2;

  always_comb begin
    sq = {32'd0, in_item.m} * {32'd0, in_item.m};
    m2 = sq[61:30];
    item_nxt = in_item;
    if (m2[31]) begin
      item_nxt.frac[BIT_POS] = 1'b1;
      item_nxt.m = {1'b0, m2[31:1]};
    end else begin
      item_nxt.m = m2;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      item_r <= item_nxt;
    end
  end

  assign out_v = v_r;
  assign out_item = item_r;

endmodule

>>> hdl/chc_exp_cell.sv
// One conditional root-multiply cell of the exp2 fraction chain.
module chc_exp_cell #(
  parameter int BIT_POS = 23
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_v,
  input  chc_pkg::item_t in_item,
  output logic          out_v,
  output chc_pkg::item_t out_item
);

  localparam logic [63:0] ROOT = chc_pkg::exp_root(BIT_POS);

  logic          v_r;
  chc_pkg::item_t item_r, item_nxt;
  logic [63:0]   prod;

  always_comb begin
    prod = {32'd0, in_item.e} * {32'd0, ROOT[31:0]};
    item_nxt = in_item;
    if (in_item.f[BIT_POS]) begin
      item_nxt.e = prod[61:30];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      item_r <= item_nxt;
    end
  end

  assign out_v = v_r;
  assign out_item = item_r;

endmodule

>>> hdl/cubehelix_color_evaluator_core.sv
// Top level of the cubehelix color evaluator: config registers and the full cell pipeline.
// Throughput: one transaction per cycle; the whole chain advances together and holds
// only while the output register is full and stalled.
// Reset: synchronous active-low; clears all valid bits and loads the register defaults.
module cubehelix_color_evaluator_core #(
  parameter int LEVEL_BITS      = chc_pkg::LEVEL_BITS_DEF,
  parameter int ROTATION_STAGES = chc_pkg::ROTATION_STAGES_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [LEVEL_BITS-1:0] in_level,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [15:0]           out_red,
  output logic [15:0]           out_green,
  output logic [15:0]           out_blue,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [3:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  localparam int ROT_SH = 24 - LEVEL_BITS;
  localparam int LOG_N  = chc_pkg::ATAN_LEN;

  // ---------------- configuration ----------------
  logic [9:0]  start_hue_r;
  logic [11:0] rotations_r;
  logic [10:0] sat_gain_r;
  logic [10:0] gamma_r;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_hue_r <= chc_pkg::START_HUE_RST;
      rotations_r <= chc_pkg::ROTATIONS_RST;
      sat_gain_r  <= chc_pkg::SAT_GAIN_RST;
      gamma_r     <= chc_pkg::GAMMA_RST;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        chc_pkg::REG_START_HUE: start_hue_r <= pwdata[9:0];
        chc_pkg::REG_ROTATIONS: rotations_r <= pwdata[11:0];
        chc_pkg::REG_SAT_GAIN:  sat_gain_r  <= pwdata[10:0];
        chc_pkg::REG_GAMMA:     gamma_r     <= pwdata[10:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      chc_pkg::REG_START_HUE: prdata = {22'd0, start_hue_r};
      chc_pkg::REG_ROTATIONS: prdata = {20'd0, rotations_r};
      chc_pkg::REG_SAT_GAIN:  prdata = {21'd0, sat_gain_r};
      chc_pkg::REG_GAMMA:     prdata = {21'd0, gamma_r};
      default:                prdata = 32'd0;
    endcase
  end

  // ---------------- flow control ----------------
  logic out_valid_r;
  logic en;

  assign en = !(out_valid_r && out_stall);
  assign in_stall = !en;

  // ---------------- input register ----------------
  logic                  v0_r;
  logic [LEVEL_BITS-1:0] lv_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (en) begin
      v0_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lv_r <= in_level;
    end
  end

  // ---------------- phase and log setup ----------------
  logic [33:0]               hue_mul;
  logic [19:0]               hue_div;
  logic [31:0]               start_term;
  logic signed [LEVEL_BITS+12:0] rot_prod;
  logic [63:0]               rot_ext;
  logic [31:0]               phase;
  logic [4:0]                lead;
  chc_pkg::item_t            item1_nxt, item1_r;
  logic                      v1_r;

  always_comb begin
    // floor(hue * 2^24 / 3) = hue * 5592405 + floor(hue / 3)
    hue_mul = 34'(start_hue_r) * 34'd5592405;
    hue_div = (20'(start_hue_r) * 20'd683) >> 11;
    start_term = hue_mul[31:0] + {12'd0, hue_div};
    rot_prod = $signed(rotations_r) * $signed({1'b0, lv_r});
    rot_ext = 64'(rot_prod) << ROT_SH;
    phase = start_term + rot_ext[31:0];
    lead = 5'd0;
    for (int i = 0; i < LEVEL_BITS; i++) begin
      if (lv_r[i]) lead = 5'(i);
    end
    item1_nxt = '0;
    item1_nxt.nz = (lv_r != '0);
    item1_nxt.q = phase[31:30];
    item1_nxt.x = chc_pkg::CORDIC_GAIN;
    item1_nxt.y = 34'sd0;
    item1_nxt.z = $signed({4'd0, phase[29:0]});
    item1_nxt.p = lead;
    item1_nxt.m = 32'(lv_r) << (5'd30 - lead);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= v0_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      item1_r <= item1_nxt;
    end
  end

  // ---------------- CORDIC chain ----------------
  chc_pkg::item_t cord_item [ROTATION_STAGES+1];
  logic           cord_v    [ROTATION_STAGES+1];

  assign cord_item[0] = item1_r;
  assign cord_v[0] = v1_r;

  for (genvar gi = 0; gi < ROTATION_STAGES; gi++) begin : g_cordic
    chc_cordic_cell #(.STAGE(gi)) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (en),
      .in_v     (cord_v[gi]),
      .in_item  (cord_item[gi]),
      .out_v    (cord_v[gi+1]),
      .out_item (cord_item[gi+1])
    );
  end

  // ---------------- quadrant map ----------------
  chc_pkg::item_t cs_nxt, cs_r;
  logic           cs_v_r;

  always_comb begin
    cs_nxt = cord_item[ROTATION_STAGES];
    case (cord_item[ROTATION_STAGES].q)
      2'd0: begin
        cs_nxt.x = cord_item[ROTATION_STAGES].x;
        cs_nxt.y = cord_item[ROTATION_STAGES].y;
      end
      2'd1: begin
        cs_nxt.x = -cord_item[ROTATION_STAGES].y;
        cs_nxt.y = cord_item[ROTATION_STAGES].x;
      end
      2'd2: begin
        cs_nxt.x = -cord_item[ROTATION_STAGES].x;
        cs_nxt.y = -cord_item[ROTATION_STAGES].y;
      end
      default: begin
        cs_nxt.x = cord_item[ROTATION_STAGES].y;
        cs_nxt.y = -cord_item[ROTATION_STAGES].x;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cs_v_r <= 1'b0;
    end else if (en) begin
      cs_v_r <= cord_v[ROTATION_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cs_r <= cs_nxt;
    end
  end

  // ---------------- log2 chain ----------------
  chc_pkg::item_t log_item [LOG_N+1];
  logic           log_v    [LOG_N+1];

  assign log_item[0] = cs_r;
  assign log_v[0] = cs_v_r;

  for (genvar gj = 0; gj < LOG_N; gj++) begin : g_log
    chc_log_cell #(.BIT_POS(LOG_N - 1 - gj)) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (en),
      .in_v     (log_v[gj]),
      .in_item  (log_item[gj]),
      .out_v    (log_v[gj+1]),
      .out_item (log_item[gj+1])
    );
  end

  // ---------------- gamma scale ----------------
  logic signed [7:0]  int_part;
  logic signed [31:0] lg;
  logic signed [43:0] gprod;
  chc_pkg::item_t     gs_nxt, gs_r;
  logic               gs_v_r;

  always_comb begin
    int_part = $signed({3'd0, log_item[LOG_N].p}) - 8'(LEVEL_BITS);
    lg = $signed({int_part, log_item[LOG_N].frac});
    gprod = $signed({1'b0, gamma_r}) * lg;
    gs_nxt = log_item[LOG_N];
    gs_nxt.n = gprod[41:32];
    gs_nxt.f = gprod[31:8];
    gs_nxt.e = chc_pkg::ONE30;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gs_v_r <= 1'b0;
    end else if (en) begin
      gs_v_r <= log_v[LOG_N];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      gs_r <= gs_nxt;
    end
  end

  // ---------------- exp2 chain ----------------
  chc_pkg::item_t exp_item [LOG_N+1];
  logic           exp_v    [LOG_N+1];

  assign exp_item[0] = gs_r;
  assign exp_v[0] = gs_v_r;

  for (genvar gk = 0; gk < LOG_N; gk++) begin : g_exp
    chc_exp_cell #(.BIT_POS(LOG_N - 1 - gk)) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (en),
      .in_v     (exp_v[gk]),
      .in_item  (exp_item[gk]),
      .out_v    (exp_v[gk+1]),
      .out_item (exp_item[gk+1])
    );
  end

  // ---------------- color tail ----------------
  chc_pkg::item_t ex;
  logic [9:0]     shamt;
  logic [31:0]    g_shift;
  logic [30:0]    g_nxt;

  assign ex = exp_item[LOG_N];

  always_comb begin
    shamt = 10'(-ex.n);
    g_shift = ex.e >> shamt[4:0];
    if (!ex.nz || shamt >= 10'd31) begin
      g_nxt = 31'd0;
    end else begin
      g_nxt = g_shift[30:0];
    end
  end

  logic               t1_v_r, t2_v_r, t3_v_r, t4_v_r, t5_v_r;
  logic [30:0]        t1_g_r, t2_g_r, t3_g_r, t4_g_r;
  logic signed [33:0] t1_c_r, t1_s_r, t2_c_r, t2_s_r, t3_c_r, t3_s_r;
  logic [29:0]        t2_pp_r;
  logic [31:0]        t3_amp_r;
  logic signed [35:0] t4_tc_r, t4_ts_r;
  logic signed [40:0] t5_r_r, t5_g_r, t5_b_r;

  logic [61:0]        pp_prod;
  logic [30:0]        one_minus_g;
  logic [40:0]        amp_prod;
  logic signed [66:0] tc_prod, ts_prod;
  logic signed [55:0] tc_x, ts_x;
  logic signed [55:0] acc_r, acc_g, acc_b;
  logic signed [40:0] gx;

  always_comb begin
    one_minus_g = 31'(chc_pkg::ONE30) - t1_g_r;
    pp_prod = {31'd0, t1_g_r} * {31'd0, one_minus_g};
    amp_prod = 41'(sat_gain_r) * 41'(t2_pp_r);
    tc_prod = $signed({1'b0, t3_amp_r}) * t3_c_r;
    ts_prod = $signed({1'b0, t3_amp_r}) * t3_s_r;
    tc_x = 56'(t4_tc_r);
    ts_x = 56'(t4_ts_r);
    acc_r = chc_pkg::W_R_C * tc_x + chc_pkg::W_R_S * ts_x;
    acc_g = chc_pkg::W_G_C * tc_x + chc_pkg::W_G_S * ts_x;
    acc_b = chc_pkg::W_B_C * tc_x;
    gx = $signed({10'd0, t4_g_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t1_v_r <= 1'b0;
      t2_v_r <= 1'b0;
      t3_v_r <= 1'b0;
      t4_v_r <= 1'b0;
      t5_v_r <= 1'b0;
    end else if (en) begin
      t1_v_r <= exp_v[LOG_N];
      t2_v_r <= t1_v_r;
      t3_v_r <= t2_v_r;
      t4_v_r <= t3_v_r;
      t5_v_r <= t4_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t1_g_r   <= g_nxt;
      t1_c_r   <= ex.x;
      t1_s_r   <= ex.y;
      t2_g_r   <= t1_g_r;
      t2_c_r   <= t1_c_r;
      t2_s_r   <= t1_s_r;
      t2_pp_r  <= pp_prod[59:30];
      t3_g_r   <= t2_g_r;
      t3_c_r   <= t2_c_r;
      t3_s_r   <= t2_s_r;
      t3_amp_r <= amp_prod[40:9];
      t4_g_r   <= t3_g_r;
      t4_tc_r  <= tc_prod[65:30];
      t4_ts_r  <= ts_prod[65:30];
      t5_r_r   <= $signed({acc_r[55], acc_r[55:16]}) + gx;
      t5_g_r   <= $signed({acc_g[55], acc_g[55:16]}) + gx;
      t5_b_r   <= $signed({acc_b[55], acc_b[55:16]}) + gx;
    end
  end

  // clamp to [0, 1.0], round to 16 bits, saturate full scale
  function automatic logic [15:0] to_out(input logic signed [40:0] v);
    logic [40:0] rnd;
    if (v < 41'sd0) begin
      return 16'd0;
    end
    if (v >= 41'sh4000_0000) begin
      return 16'hFFFF;
    end
    rnd = 41'(v) + 41'd8192;
    return (rnd[30:14] > 17'd65535) ? 16'hFFFF : rnd[29:14];
  endfunction

  logic [15:0] red_r, green_r, blue_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= t5_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      red_r   <= to_out(t5_r_r);
      green_r <= to_out(t5_g_r);
      blue_r  <= to_out(t5_b_r);
    end
  end

  assign out_valid = out_valid_r;
  assign out_red   = red_r;
  assign out_green = green_r;
  assign out_blue  = blue_r;

  // ---------------- assertions ----------------
  a_cs_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    cs_v_r |-> (cs_r.x <= 34'sd1610612736) && (cs_r.x >= -34'sd1610612736) &&
               (cs_r.y <= 34'sd1610612736) && (cs_r.y >= -34'sd1610612736))
    else $error("cos/sin out of range after quadrant map");

  a_log_mant: assert property (@(posedge clk) disable iff (!rst_n)
    (log_v[LOG_N] && log_item[LOG_N].nz) |-> (log_item[LOG_N].m[31:30] == 2'b01))
    else $error("log mantissa left [1,2)");

  a_exp_range: assert property (@(posedge clk) disable iff (!rst_n)
    exp_v[LOG_N] |-> (exp_item[LOG_N].e[31:30] == 2'b01))
    else $error("exp2 product left [1,2)");

  a_g_range: assert property (@(posedge clk) disable iff (!rst_n)
    t1_v_r |-> (t1_g_r <= 31'h4000_0000))
    else $error("gamma level above one");

endmodule
